@@ rtl/core/tdpt_pkg.sv @@
// Shared constants and control types for the trial division prime tester.
package tdpt_pkg;

   localparam int CANDIDATE_BITS = 32;

   // start pulse toward the serial remainder unit
   typedef struct packed {
      logic start;
   } rem_ctl_type;

   // one-cycle completion flag and remainder-is-zero flag from the unit
   typedef struct packed {
      logic done;
      logic zero;
   } rem_sts_type;

endpackage

@@ rtl/core/tdpt_if.sv @@
// Request and response channel interfaces of the prime tester.
interface tdpt_req_if;
   import tdpt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CANDIDATE_BITS-1:0] candidate;
   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;
   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

@@ rtl/core/tdpt_rem.sv @@
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module tdpt_rem #(
   parameter int VALUE_BITS = 32,
   parameter int DIV_BITS   = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdpt_pkg::rem_ctl_type   ctl,
   input  logic [VALUE_BITS-1:0]   dividend,
   input  logic [DIV_BITS-1:0]     divisor,
   output tdpt_pkg::rem_sts_type   sts
);
   import tdpt_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  zero_ff, zero_in;
   logic [DIV_BITS:0]     trial;
   logic [DIV_BITS:0]     reduced;

   // shift in the next dividend bit, subtract the divisor if it fits
   assign trial   = {rem_ff, shift_ff[VALUE_BITS-1]};
   assign reduced = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      if (ctl.start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         rem_in   = reduced[DIV_BITS-1:0];
         cnt_in   = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zero_in = (reduced == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      zero_ff  <= zero_in;
   end

   assign sts.done = done_ff;
   assign sts.zero = zero_ff;

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// Top level: trial division primality test with a bit-serial remainder unit.
// Flow: 0 and 1 go straight from idle to the finish state; larger candidates alternate
//   the square check with a serial remainder for each divisor from 2 upward, until a
//   divisor leaves no remainder or its square exceeds the candidate.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous, active high; clears control and the response valid.
module trial_division_prime_test #(
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   tdpt_req_if.sink          req_bus,
   tdpt_rsp_if.source        rsp_bus
);
   import tdpt_pkg::*;

   localparam int DIV_BITS = VALUE_BITS / 2 + 1;
   localparam int SQ_BITS  = 2 * DIV_BITS;
   localparam int EXT_BITS = VALUE_BITS + CANDIDATE_BITS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [DIV_BITS-1:0]   div_ff, div_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic                  prime_ff, prime_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_prime_ff, rsp_prime_in;

   logic [EXT_BITS-1:0]   cand_ext;
   logic [VALUE_BITS-1:0] cand_trim;
   logic                  accept;
   logic                  rsp_free;
   rem_ctl_type           rem_ctl;
   rem_sts_type           rem_sts;

   assign cand_ext  = {VALUE_BITS'(0), req_bus.candidate};
   assign cand_trim = cand_ext[VALUE_BITS-1:0];

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      div_in        = div_ff;
      sq_in         = sq_ff;
      prime_in      = prime_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_prime_in  = rsp_prime_ff;
      rem_ctl.start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cand_in = cand_trim;
               div_in  = DIV_BITS'(2);
               sq_in   = SQ_BITS'(4);
               if (cand_trim < VALUE_BITS'(2)) begin
                  prime_in = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  prime_in = 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // divisor past the square root: no factor left to find
            if (sq_ff > SQ_BITS'(cand_ff)) begin
               state_in = S_FINISH;
            end else begin
               rem_ctl.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_sts.done) begin
               if (rem_sts.zero) begin
                  prime_in = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  div_in   = div_ff + DIV_BITS'(1);
                  sq_in    = sq_ff + SQ_BITS'({div_ff, 1'b1});
                  state_in = S_CHECK;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_ff       <= DIV_BITS'(2);
         sq_ff        <= SQ_BITS'(4);
         prime_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         sq_ff        <= sq_in;
         prime_ff     <= prime_in;
      end
      cand_ff      <= cand_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   tdpt_rem #(
      .VALUE_BITS (VALUE_BITS),
      .DIV_BITS   (DIV_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (rem_ctl),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .sts      (rem_sts)
   );

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.is_prime = rsp_prime_ff;

   // running square must track the divisor exactly
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (sq_ff == SQ_BITS'(div_ff) * SQ_BITS'(div_ff)))
      else $error("divisor square out of step");

   // remainder unit only reports while the controller waits on it
   assert property (@(posedge clock) disable iff (reset)
      rem_sts.done |-> (state_ff == S_DIV))
      else $error("remainder done outside divide state");

   // a division is only launched for a divisor no larger than the square root
   assert property (@(posedge clock) disable iff (reset)
      rem_ctl.start |-> ((div_ff >= DIV_BITS'(2)) && (sq_ff <= SQ_BITS'(cand_ff))))
      else $error("trial divisor out of range");

endmodule
